// ===== rtl/core/bmpgs_pkg.sv =====
// ----------------------------------------------------------------------------
// bmpgs_pkg: shared types and constants of the BMP grayscale pixel stream
// Field widths, luma coefficients, the reciprocal used for the divide by 255
// and the pixel record passed from the byte tracker to the output pipeline.
// ----------------------------------------------------------------------------
`default_nettype none

package bmpgs_pkg;

   // Largest image the counters cover.
   localparam int MAX_WIDTH  = 2048;
   localparam int MAX_HEIGHT = 2048;

   localparam int COL_W  = $clog2(MAX_WIDTH);
   localparam int ROW_W  = $clog2(MAX_HEIGHT);
   localparam int SIZE_W = 12;   // width of the size registers
   localparam int BYTE_W = 8;
   localparam int GRAY_W = 16;
   localparam int IDX_W  = 22;
   localparam int SUM_W  = 24;   // weighted sum, at most 65535 * 255

   // Configuration register indexes.
   localparam int CSR_IDX_W = 2;
   localparam logic [CSR_IDX_W-1:0] CSR_IMAGE_WIDTH  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_IMAGE_HEIGHT = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_GRAY_INPUT   = 2'd2;

   // BT.601 weights scaled so that full-scale white sums to 65528 * 255.
   localparam logic [SUM_W-1:0] COEF_R = 24'd19588;
   localparam logic [SUM_W-1:0] COEF_G = 24'd38469;
   localparam logic [SUM_W-1:0] COEF_B = 24'd7471;
   // Gray bytes are scaled by 257 * 255 so they share the divide by 255.
   localparam logic [SUM_W-1:0] COEF_GRAY = 24'd65535;

   // floor(x / 255) == (x * RECIP) >> RECIP_SHIFT for every x below 2^32 / 254,
   // which covers the whole weighted-sum range.
   localparam int RECIP_W     = 25;
   localparam int RECIP_SHIFT = 32;
   localparam int PROD_W      = SUM_W + RECIP_W;
   localparam logic [RECIP_W-1:0] RECIP = 25'd16843010;

   // One pixel leaving the byte tracker.
   typedef struct packed {
      logic             emit;
      logic [SUM_W-1:0] luma_sum;
      logic [IDX_W-1:0] pixel_index;
      logic             frame_last;
   } pixel_type;

endpackage

`default_nettype wire

// ===== rtl/core/bmpgs_byte_tracker.sv =====
// ----------------------------------------------------------------------------
// bmpgs_byte_tracker: per-byte position and colour collection
// Follows B,G,R phase, row padding, column, row and row base, and forms the
// weighted luma sum and top-down index for each byte that completes a pixel.
// ----------------------------------------------------------------------------
`default_nettype none

module bmpgs_byte_tracker (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           accept,
   input  wire logic [bmpgs_pkg::BYTE_W-1:0]   data_byte,
   input  wire logic [bmpgs_pkg::SIZE_W-1:0]   image_width,
   input  wire logic [bmpgs_pkg::SIZE_W-1:0]   image_height,
   input  wire logic                           gray_input,
   output bmpgs_pkg::pixel_type                pixel
);

   logic [bmpgs_pkg::COL_W-1:0]  column_ff, column_in;
   logic [bmpgs_pkg::ROW_W-1:0]  row_ff, row_in;
   logic [1:0]                   phase_ff, phase_in;
   logic [1:0]                   pad_ff, pad_in;
   logic [bmpgs_pkg::BYTE_W-1:0] blue_ff, blue_in;
   logic [bmpgs_pkg::BYTE_W-1:0] green_ff, green_in;
   logic [bmpgs_pkg::IDX_W-1:0]  base_ff, base_in;

   logic [bmpgs_pkg::SIZE_W-1:0]   w_eff, h_eff;
   logic [2*bmpgs_pkg::SIZE_W-1:0] top_base;
   logic [bmpgs_pkg::IDX_W-1:0]    base_cur;
   logic                           row_end, last;
   logic [bmpgs_pkg::SUM_W-1:0]    sum;

   // Sizes of zero act as one, sizes past the maximum act as the maximum.
   always_comb begin
      if (image_width == '0) begin
         w_eff = bmpgs_pkg::SIZE_W'(1);
      end else if (image_width > bmpgs_pkg::SIZE_W'(bmpgs_pkg::MAX_WIDTH)) begin
         w_eff = bmpgs_pkg::SIZE_W'(bmpgs_pkg::MAX_WIDTH);
      end else begin
         w_eff = image_width;
      end
      if (image_height == '0) begin
         h_eff = bmpgs_pkg::SIZE_W'(1);
      end else if (image_height > bmpgs_pkg::SIZE_W'(bmpgs_pkg::MAX_HEIGHT)) begin
         h_eff = bmpgs_pkg::SIZE_W'(bmpgs_pkg::MAX_HEIGHT);
      end else begin
         h_eff = image_height;
      end
   end

   assign top_base = w_eff * (h_eff - bmpgs_pkg::SIZE_W'(1));
   assign base_cur = (column_ff == '0 && row_ff == '0)
                   ? top_base[bmpgs_pkg::IDX_W-1:0] : base_ff;
   assign row_end  = (bmpgs_pkg::SIZE_W'(column_ff) + bmpgs_pkg::SIZE_W'(1)) >= w_eff;
   assign last     = row_end
                   && ((bmpgs_pkg::SIZE_W'(row_ff) + bmpgs_pkg::SIZE_W'(1)) >= h_eff);

   always_comb begin
      if (gray_input) begin
         sum = bmpgs_pkg::COEF_GRAY * bmpgs_pkg::SUM_W'(data_byte);
      end else begin
         sum = bmpgs_pkg::COEF_R * bmpgs_pkg::SUM_W'(data_byte)
             + bmpgs_pkg::COEF_G * bmpgs_pkg::SUM_W'(green_ff)
             + bmpgs_pkg::COEF_B * bmpgs_pkg::SUM_W'(blue_ff);
      end
   end

   always_comb begin
      column_in  = column_ff;
      row_in     = row_ff;
      phase_in   = phase_ff;
      pad_in     = pad_ff;
      blue_in    = blue_ff;
      green_in   = green_ff;
      base_in    = base_ff;
      pixel.emit        = 1'b0;
      pixel.luma_sum    = sum;
      pixel.pixel_index = base_cur + bmpgs_pkg::IDX_W'(column_ff);
      pixel.frame_last  = last;
      if (pad_ff != 2'd0) begin
         pad_in = pad_ff - 2'd1;
      end else if (!gray_input && phase_ff == 2'd0) begin
         blue_in  = data_byte;
         phase_in = 2'd1;
      end else if (!gray_input && phase_ff == 2'd1) begin
         green_in = data_byte;
         phase_in = 2'd2;
      end else begin
         pixel.emit = 1'b1;
         phase_in   = 2'd0;
         base_in    = base_cur;
         if (row_end) begin
            column_in = '0;
            // Rows align to four bytes: three bytes a pixel need w mod 4
            // padding bytes, one byte a pixel need -w mod 4.
            pad_in = gray_input ? (2'd0 - w_eff[1:0]) : w_eff[1:0];
            if (last) begin
               row_in = '0;
            end else begin
               row_in  = row_ff + bmpgs_pkg::ROW_W'(1);
               base_in = base_cur - bmpgs_pkg::IDX_W'(w_eff);
            end
         end else begin
            column_in = column_ff + bmpgs_pkg::COL_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         column_ff <= '0;
         row_ff    <= '0;
         phase_ff  <= '0;
         pad_ff    <= '0;
         blue_ff   <= '0;
         green_ff  <= '0;
         base_ff   <= '0;
      end else if (accept) begin
         column_ff <= column_in;
         row_ff    <= row_in;
         phase_ff  <= phase_in;
         pad_ff    <= pad_in;
         blue_ff   <= blue_in;
         green_ff  <= green_in;
         base_ff   <= base_in;
      end
   end

endmodule

`default_nettype wire

// ===== rtl/core/bmp_pixel_grayscale_stream_unit.sv =====
// ----------------------------------------------------------------------------
// bmp_pixel_grayscale_stream_unit: BMP pixel bytes to normalized luma
// Turns raw bottom-up BMP pixel data into top-down 16-bit grayscale pixels.
// ----------------------------------------------------------------------------
// Usage:
// The req channel takes one raw pixel-data byte per item, row padding
// included. Blue and green bytes of a colour triple, and padding bytes,
// produce no result item; the red byte (or every pixel byte in gray mode)
// produces one rsp item with the luma, its top-down index and a flag on the
// last pixel of the frame.
// Throughput is one item per cycle while rsp does not stall. A result item
// is registered first in the sum stage, with the weighted sum and index,
// then in the output register, after the constant-reciprocal divide by 255.
// When rsp is stalled on a full output register, it and the sum stage hold;
// req stall rises only once the sum stage is full and cannot move on.
// Reset clears the position counters and all valid flags and loads width 1,
// height 1 and colour mode. The csr channel is always ready and should be
// written only while no item is in flight; size and mode registers feed the
// byte tracker directly. After the last pixel and its padding the counters
// wrap and the next frame starts.
// ----------------------------------------------------------------------------
`default_nettype none

module bmp_pixel_grayscale_stream_unit (
   input  wire logic                              clock,
   input  wire logic                              reset,
   // Pixel byte input.
   input  wire logic                              req_valid,
   output logic                                   req_stall,
   input  wire logic [bmpgs_pkg::BYTE_W-1:0]      req_data_byte,
   // Pixel result output.
   output logic                                   rsp_valid,
   input  wire logic                              rsp_stall,
   output logic [bmpgs_pkg::GRAY_W-1:0]           rsp_gray_value,
   output logic [bmpgs_pkg::IDX_W-1:0]            rsp_pixel_index,
   output logic                                   rsp_frame_last,
   // Register writes.
   input  wire logic                              csr_valid,
   output logic                                   csr_ready,
   input  wire logic [bmpgs_pkg::CSR_IDX_W-1:0]   csr_index,
   input  wire logic [bmpgs_pkg::SIZE_W-1:0]      csr_data
);

   // Configuration registers.
   logic [bmpgs_pkg::SIZE_W-1:0] width_ff;
   logic [bmpgs_pkg::SIZE_W-1:0] height_ff;
   logic                         gray_ff;

   // Sum stage.
   logic                         s1_valid_ff, s1_valid_in;
   logic [bmpgs_pkg::SUM_W-1:0]  s1_sum_ff;
   logic [bmpgs_pkg::IDX_W-1:0]  s1_index_ff;
   logic                         s1_last_ff;

   // Output register.
   logic                          out_valid_ff, out_valid_in;
   logic [bmpgs_pkg::GRAY_W-1:0]  out_gray_ff;
   logic [bmpgs_pkg::IDX_W-1:0]   out_index_ff;
   logic                          out_last_ff;

   logic                          out_free, s1_move, accept;
   logic [bmpgs_pkg::PROD_W-1:0]  product;
   bmpgs_pkg::pixel_type          pixel;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= bmpgs_pkg::SIZE_W'(1);
         height_ff <= bmpgs_pkg::SIZE_W'(1);
         gray_ff   <= 1'b0;
      end else if (csr_valid) begin
         case (csr_index)
            bmpgs_pkg::CSR_IMAGE_WIDTH:  width_ff  <= csr_data;
            bmpgs_pkg::CSR_IMAGE_HEIGHT: height_ff <= csr_data;
            bmpgs_pkg::CSR_GRAY_INPUT:   gray_ff   <= csr_data[0];
            default: ;
         endcase
      end
   end

   // The output register empties when taken; the sum stage moves into it
   // whenever it is free, and the sum stage takes a byte when it is empty or
   // moving on.
   assign out_free  = !out_valid_ff || !rsp_stall;
   assign s1_move   = s1_valid_ff && out_free;
   assign req_stall = s1_valid_ff && !out_free;
   assign accept    = req_valid && !req_stall;

   bmpgs_byte_tracker u_tracker (
      .clock        (clock),
      .reset        (reset),
      .accept       (accept),
      .data_byte    (req_data_byte),
      .image_width  (width_ff),
      .image_height (height_ff),
      .gray_input   (gray_ff),
      .pixel        (pixel)
   );

   always_comb begin
      if (accept) begin
         s1_valid_in = pixel.emit;
      end else if (s1_move) begin
         s1_valid_in = 1'b0;
      end else begin
         s1_valid_in = s1_valid_ff;
      end
      if (s1_move) begin
         out_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         out_valid_in = 1'b0;
      end else begin
         out_valid_in = out_valid_ff;
      end
   end

   // Divide by 255 as a multiply by a rounded-up reciprocal.
   assign product = bmpgs_pkg::PROD_W'(s1_sum_ff) * bmpgs_pkg::PROD_W'(bmpgs_pkg::RECIP);

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept && pixel.emit) begin
         s1_sum_ff   <= pixel.luma_sum;
         s1_index_ff <= pixel.pixel_index;
         s1_last_ff  <= pixel.frame_last;
      end
      if (s1_move) begin
         out_gray_ff  <= product[bmpgs_pkg::RECIP_SHIFT +: bmpgs_pkg::GRAY_W];
         out_index_ff <= s1_index_ff;
         out_last_ff  <= s1_last_ff;
      end
   end

   assign rsp_valid       = out_valid_ff;
   assign rsp_gray_value  = out_gray_ff;
   assign rsp_pixel_index = out_index_ff;
   assign rsp_frame_last  = out_last_ff;

endmodule

`default_nettype wire

// ===== test/bmp_pixel_grayscale_stream_unit_tb.sv =====
// ----------------------------------------------------------------------------
// bmp_pixel_grayscale_stream_unit_tb: self-checking bench for the BMP luma stream
// Feeds raw bitmap pixel bytes, padding included, through the req channel and
// checks every rsp item against a cycle-free model of the byte tracker. A short
// scripted part covers reset values, full-scale colour and gray bytes, size
// clamping, resizing in the middle of a frame and the wrap of the row base.
// Random frames of mostly small sizes follow, with random idling on both sides.
// ----------------------------------------------------------------------------
`default_nettype none

module bmp_pixel_grayscale_stream_unit_tb;

   localparam int CYCLE_LIMIT        = 400000;
   localparam int RANDOM_BYTES       = 1000;
   localparam int MISMATCH_SHOWN     = 10;
   localparam int SETTLE_CYCLES      = 4;     // pipeline depth plus margin
   localparam int FRAME_BYTE_CAP     = 600;   // longer frames are sent in part
   localparam int unsigned WEIGHT_R   = 19588;
   localparam int unsigned WEIGHT_G   = 38469;
   localparam int unsigned WEIGHT_B   = 7471;
   localparam int unsigned GRAY_SCALE = 257;

   // One result item as it should leave the block.
   typedef struct packed {
      logic [bmpgs_pkg::GRAY_W-1:0] gray;
      logic [bmpgs_pkg::IDX_W-1:0]  index;
      logic                         last;
   } pixel_rec_type;

   // One row of the scripted part: either a pixel byte or a register write.
   // A pinned byte carries the result typed in by hand instead of the
   // predicted one.
   typedef enum logic {STEP_BYTE, STEP_WRITE} step_kind_type;
   typedef struct packed {
      step_kind_type                   kind;
      logic [bmpgs_pkg::CSR_IDX_W-1:0] reg_index;
      logic [bmpgs_pkg::SIZE_W-1:0]    value;
      logic                            pinned;
      pixel_rec_type                   want;
   } script_step_type;

   logic                            clock = 1'b0;
   logic                            reset;
   logic                            req_valid;
   logic                            req_stall;
   logic [bmpgs_pkg::BYTE_W-1:0]    req_data_byte;
   logic                            rsp_valid;
   logic                            rsp_stall;
   logic [bmpgs_pkg::GRAY_W-1:0]    rsp_gray_value;
   logic [bmpgs_pkg::IDX_W-1:0]     rsp_pixel_index;
   logic                            rsp_frame_last;
   logic                            csr_valid;
   logic                            csr_ready;
   logic [bmpgs_pkg::CSR_IDX_W-1:0] csr_index;
   logic [bmpgs_pkg::SIZE_W-1:0]    csr_data;

   // Shadow copy of the configuration registers and of the byte tracker.
   logic [bmpgs_pkg::SIZE_W-1:0] cfg_width;
   logic [bmpgs_pkg::SIZE_W-1:0] cfg_height;
   logic                         cfg_gray;
   logic [bmpgs_pkg::COL_W-1:0]  col_pos;
   logic [bmpgs_pkg::ROW_W-1:0]  row_pos;
   logic [1:0]                   triple_phase;
   logic [1:0]                   pad_left;
   logic [bmpgs_pkg::BYTE_W-1:0] blue_q;
   logic [bmpgs_pkg::BYTE_W-1:0] green_q;
   logic [bmpgs_pkg::IDX_W-1:0]  row_base_q;

   // Pixels predicted but not yet seen on rsp, oldest first.
   pixel_rec_type   pending_pixels[$];
   script_step_type dir_script[$];

   pixel_rec_type want_px;
   bit            steady;
   int unsigned   stall_hold;
   int unsigned   cycle_count;
   int unsigned   mismatch_count;
   int unsigned   pixels_checked;
   int unsigned   frames_closed;
   int unsigned   bytes_fed;
   int unsigned   pixel_bytes;
   int unsigned   writes_done;
   int unsigned   phases_run;

   bmp_pixel_grayscale_stream_unit dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_data_byte   (req_data_byte),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_gray_value  (rsp_gray_value),
      .rsp_pixel_index (rsp_pixel_index),
      .rsp_frame_last  (rsp_frame_last),
      .csr_valid       (csr_valid),
      .csr_ready       (csr_ready),
      .csr_index       (csr_index),
      .csr_data        (csr_data)
   );

   always #5 clock = ~clock;

   // A size of zero behaves as one, anything above the maximum as the maximum.
   function automatic int unsigned clamp_dim(input logic [bmpgs_pkg::SIZE_W-1:0] v,
                                             input int unsigned maxv);
      if (v == '0) return 1;
      if (v > maxv) return maxv;
      return v;
   endfunction

   // Advances the shadow tracker by one accepted byte. Returns 1 and fills px
   // when the byte completes a pixel; padding, blue and green bytes return 0.
   function automatic bit luma_step(input logic [bmpgs_pkg::BYTE_W-1:0] b,
                                    output pixel_rec_type px);
      int unsigned w;
      int unsigned h;
      int unsigned sum;
      int unsigned per_pixel;
      logic        row_end;
      px = '0;
      if (pad_left != 2'd0) begin
         pad_left = pad_left - 2'd1;
         return 1'b0;
      end
      pixel_bytes++;
      if (!cfg_gray) begin
         if (triple_phase == 2'd0) begin
            blue_q       = b;
            triple_phase = 2'd1;
            return 1'b0;
         end
         if (triple_phase == 2'd1) begin
            green_q      = b;
            triple_phase = 2'd2;
            return 1'b0;
         end
         sum       = WEIGHT_R * b + WEIGHT_G * green_q + WEIGHT_B * blue_q;
         px.gray   = bmpgs_pkg::GRAY_W'(sum / 255);
         per_pixel = 3;
      end else begin
         // Gray mode also drops any half-collected colour triple.
         px.gray   = bmpgs_pkg::GRAY_W'(b * GRAY_SCALE);
         per_pixel = 1;
      end
      triple_phase = 2'd0;
      w = clamp_dim(cfg_width, bmpgs_pkg::MAX_WIDTH);
      h = clamp_dim(cfg_height, bmpgs_pkg::MAX_HEIGHT);
      // The first pixel of a frame lands on the top-down index of the bottom row.
      if (col_pos == '0 && row_pos == '0) row_base_q = bmpgs_pkg::IDX_W'(w * (h - 1));
      px.index = row_base_q + bmpgs_pkg::IDX_W'(col_pos);
      row_end  = (int'(col_pos) + 1 >= w);
      px.last  = row_end && (int'(row_pos) + 1 >= h);
      if (row_end) begin
         col_pos  = '0;
         pad_left = 2'((4 - ((w * per_pixel) & 3)) & 3);
         if (px.last) begin
            row_pos = '0;
         end else begin
            row_pos    = row_pos + 1'b1;
            row_base_q = row_base_q - bmpgs_pkg::IDX_W'(w);
         end
      end else begin
         col_pos = col_pos + 1'b1;
      end
      return 1'b1;
   endfunction

   // Bytes in one whole frame at the current size and mode, padding included.
   function automatic int unsigned frame_bytes();
      int unsigned w;
      int unsigned h;
      int unsigned row_len;
      w       = clamp_dim(cfg_width, bmpgs_pkg::MAX_WIDTH) * (cfg_gray ? 1 : 3);
      h       = clamp_dim(cfg_height, bmpgs_pkg::MAX_HEIGHT);
      row_len = w + ((4 - (w & 3)) & 3);
      return h * row_len;
   endfunction

   // Mostly small sizes, sometimes mid-sized, now and then zero, the maximum,
   // one past it, all ones or anything at all.
   function automatic logic [bmpgs_pkg::SIZE_W-1:0] pick_size(input int unsigned small_hi,
                                                              input int unsigned mid_hi,
                                                              input int unsigned maxv);
      int unsigned roll;
      roll = $urandom_range(0, 19);
      case (roll)
         0:          return '0;
         1:          return '1;
         2:          return bmpgs_pkg::SIZE_W'(maxv);
         3:          return bmpgs_pkg::SIZE_W'(maxv + 1);
         4:          return bmpgs_pkg::SIZE_W'($urandom_range(0, (1 << bmpgs_pkg::SIZE_W) - 1));
         5, 6, 7, 8: return bmpgs_pkg::SIZE_W'($urandom_range(small_hi + 1, mid_hi));
         default:    return bmpgs_pkg::SIZE_W'($urandom_range(1, small_hi));
      endcase
   endfunction

   function automatic script_step_type byte_step(input logic [bmpgs_pkg::BYTE_W-1:0] b);
      script_step_type s;
      s       = '0;
      s.kind  = STEP_BYTE;
      s.value = bmpgs_pkg::SIZE_W'(b);
      return s;
   endfunction

   function automatic script_step_type pinned_step(input logic [bmpgs_pkg::BYTE_W-1:0] b,
                                                   input logic [bmpgs_pkg::GRAY_W-1:0] gray,
                                                   input logic [bmpgs_pkg::IDX_W-1:0] index,
                                                   input logic last);
      script_step_type s;
      s            = byte_step(b);
      s.pinned     = 1'b1;
      s.want.gray  = gray;
      s.want.index = index;
      s.want.last  = last;
      return s;
   endfunction

   function automatic script_step_type write_step(input logic [bmpgs_pkg::CSR_IDX_W-1:0] idx,
                                                  input logic [bmpgs_pkg::SIZE_W-1:0] data);
      script_step_type s;
      s           = '0;
      s.kind      = STEP_WRITE;
      s.reg_index = idx;
      s.value     = data;
      return s;
   endfunction

   // Presents one byte after a random gap and returns at the edge that took
   // it. Valid stays high on return so that a back-to-back byte needs no
   // second assignment in the same step.
   task automatic send_byte(input logic [bmpgs_pkg::BYTE_W-1:0] data, input logic pinned,
                            input pixel_rec_type want);
      int unsigned   gap;
      pixel_rec_type px;
      gap = steady ? 0 : $urandom_range(0, 4);
      csr_valid <= 1'b0;
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid     <= 1'b1;
      req_data_byte <= data;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      bytes_fed++;
      if (luma_step(data, px)) pending_pixels.push_back(pinned ? want : px);
   endtask

   // Writes one register; the shadow copy follows at the accepting edge.
   task automatic write_reg(input logic [bmpgs_pkg::CSR_IDX_W-1:0] idx,
                            input logic [bmpgs_pkg::SIZE_W-1:0] data);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= data;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      writes_done++;
      case (idx)
         bmpgs_pkg::CSR_IMAGE_WIDTH:  cfg_width  = data;
         bmpgs_pkg::CSR_IMAGE_HEIGHT: cfg_height = data;
         bmpgs_pkg::CSR_GRAY_INPUT:   cfg_gray   = data[0];
         default: ;
      endcase
   endtask

   // Stops feeding bytes and waits until every predicted pixel has come out.
   // Blue, green and padding bytes leave nothing behind to wait for, so a few
   // extra cycles let the pipeline empty before any register changes.
   task automatic settle();
      req_valid <= 1'b0;
      while (pending_pixels.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // The receiver holds off results with random stalls, except during
   // steady phases where it takes everything at once.
   always @(posedge clock) begin
      if (reset) begin
         stall_hold = 0;
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) stall_hold = steady ? 0 : $urandom_range(0, 4);
         if (stall_hold > 0) begin
            rsp_stall <= 1'b1;
            stall_hold--;
         end else begin
            rsp_stall <= 1'b0;
         end
      end
   end

   // Every accepted result is matched against the oldest predicted pixel.
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_pixels.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= MISMATCH_SHOWN)
               $display("unexpected pixel: gray %0d index %0d last %0b",
                        rsp_gray_value, rsp_pixel_index, rsp_frame_last);
         end else begin
            want_px = pending_pixels.pop_front();
            pixels_checked++;
            if (rsp_frame_last) frames_closed++;
            if (rsp_gray_value !== want_px.gray || rsp_pixel_index !== want_px.index ||
                rsp_frame_last !== want_px.last) begin
               mismatch_count++;
               if (mismatch_count <= MISMATCH_SHOWN)
                  $display("pixel %0d mismatch: gray %0d/%0d index %0d/%0d last %0b/%0b %s",
                           pixels_checked, rsp_gray_value, want_px.gray, rsp_pixel_index,
                           want_px.index, rsp_frame_last, want_px.last, "(actual/expected)");
            end
         end
      end
   end

   // Watchdog: a hung handshake ends the run as a failure.
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("timeout after %0d cycles with %0d pixels outstanding",
                  cycle_count, pending_pixels.size());
         $display("Verification failed");
         $finish;
      end
   end

   initial begin
      int unsigned burst;
      int unsigned frame_len;
      int unsigned random_start;
      int unsigned budget_left;
      bit          first;
      reset         = 1'b1;
      req_valid     = 1'b0;
      req_data_byte = '0;
      csr_valid     = 1'b0;
      csr_index     = '0;
      csr_data      = '0;
      steady        = 1'b0;
      // Reset state: width 1, height 1, colour mode, tracker at frame start.
      cfg_width     = bmpgs_pkg::SIZE_W'(1);
      cfg_height    = bmpgs_pkg::SIZE_W'(1);
      cfg_gray      = 1'b0;
      col_pos       = '0;
      row_pos       = '0;
      triple_phase  = 2'd0;
      pad_left      = 2'd0;
      blue_q        = '0;
      green_q       = '0;
      row_base_q    = '0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // At reset sizes a colour pixel is one triple plus one padding byte,
      // and every pixel closes the frame at index 0.
      dir_script.push_back(byte_step(8'h00));
      dir_script.push_back(byte_step(8'h00));
      dir_script.push_back(pinned_step(8'h00, 16'd0, 22'd0, 1'b1));
      dir_script.push_back(byte_step(8'h5A));
      // Full-scale white: the three weights sum to 65528.
      dir_script.push_back(byte_step(8'hFF));
      dir_script.push_back(byte_step(8'hFF));
      dir_script.push_back(pinned_step(8'hFF, 16'd65528, 22'd0, 1'b1));
      dir_script.push_back(byte_step(8'hA5));
      // A lone blue byte, then gray mode: the held byte must be dropped.
      // Zero sizes act as one, so the gray pixel closes the frame and
      // three padding bytes follow.
      dir_script.push_back(byte_step(8'h12));
      dir_script.push_back(write_step(bmpgs_pkg::CSR_GRAY_INPUT, bmpgs_pkg::SIZE_W'(1)));
      dir_script.push_back(write_step(bmpgs_pkg::CSR_IMAGE_WIDTH, '0));
      dir_script.push_back(write_step(bmpgs_pkg::CSR_IMAGE_HEIGHT, '0));
      dir_script.push_back(pinned_step(8'hFF, 16'd65535, 22'd0, 1'b1));
      dir_script.push_back(byte_step(8'h33));
      dir_script.push_back(byte_step(8'hCC));
      dir_script.push_back(byte_step(8'h0F));
      // Oversized registers clamp to 2048 x 2048; the first pixel lands on
      // the first column of the bottom row of the top-down image.
      dir_script.push_back(write_step(bmpgs_pkg::CSR_IMAGE_WIDTH, '1));
      dir_script.push_back(write_step(bmpgs_pkg::CSR_IMAGE_HEIGHT, '1));
      dir_script.push_back(pinned_step(8'h00, 16'd0, 22'd4192256, 1'b0));
      dir_script.push_back(byte_step(8'h01));
      // Shrinking mid-frame past the current column ends the row and the
      // frame at the next pixel.
      dir_script.push_back(write_step(bmpgs_pkg::CSR_IMAGE_WIDTH, bmpgs_pkg::SIZE_W'(2)));
      dir_script.push_back(write_step(bmpgs_pkg::CSR_IMAGE_HEIGHT, bmpgs_pkg::SIZE_W'(1)));
      dir_script.push_back(byte_step(8'h80));
      dir_script.push_back(byte_step(8'hF0));
      dir_script.push_back(byte_step(8'h0F));
      // A frame begun one row high that is then made taller: the row base
      // steps below zero and wraps to the top of the index range.
      dir_script.push_back(byte_step(8'h40));
      dir_script.push_back(write_step(bmpgs_pkg::CSR_IMAGE_HEIGHT, bmpgs_pkg::SIZE_W'(3)));
      dir_script.push_back(byte_step(8'hC0));
      dir_script.push_back(byte_step(8'h55));
      dir_script.push_back(byte_step(8'hAA));
      dir_script.push_back(byte_step(8'h01));

      for (int i = 0; i < dir_script.size(); i++) begin
         if (dir_script[i].kind == STEP_WRITE) begin
            if (i == 0 || dir_script[i-1].kind == STEP_BYTE) settle();
            write_reg(dir_script[i].reg_index, dir_script[i].value);
         end else begin
            send_byte(dir_script[i].value[bmpgs_pkg::BYTE_W-1:0], dir_script[i].pinned,
                      dir_script[i].want);
         end
      end

      // Random phases. Each one drains the block, rewrites some registers
      // (all of them the first time) and then sends one to three whole
      // frames of random bytes. One phase in ten sends a short broken burst
      // instead, and frames too long to send whole are cut short, so the
      // next phase resizes in the middle of a frame. The last burst is
      // trimmed so the random part sends its byte budget and no more.
      random_start = bytes_fed;
      first        = 1'b1;
      while (bytes_fed - random_start < RANDOM_BYTES) begin
         settle();
         phases_run++;
         steady = ($urandom_range(0, 3) == 0);
         if (first || $urandom_range(0, 9) < 7)
            write_reg(bmpgs_pkg::CSR_IMAGE_WIDTH, pick_size(8, 40, bmpgs_pkg::MAX_WIDTH));
         if (first || $urandom_range(0, 9) < 7)
            write_reg(bmpgs_pkg::CSR_IMAGE_HEIGHT, pick_size(4, 12, bmpgs_pkg::MAX_HEIGHT));
         if (first || $urandom_range(0, 9) < 7)
            write_reg(bmpgs_pkg::CSR_GRAY_INPUT, bmpgs_pkg::SIZE_W'($urandom_range(0, 1)));
         first = 1'b0;
         if ($urandom_range(0, 9) == 0) begin
            burst = $urandom_range(1, 20);
         end else begin
            frame_len = frame_bytes();
            burst = (frame_len > FRAME_BYTE_CAP) ? $urandom_range(20, 200)
                                                 : frame_len * $urandom_range(1, 3);
         end
         budget_left = RANDOM_BYTES - (bytes_fed - random_start);
         if (burst > budget_left) burst = budget_left;
         repeat (burst) send_byte(bmpgs_pkg::BYTE_W'($urandom()), 1'b0, '0);
      end

      settle();
      $display("fed %0d bytes (%0d pixel bytes) in %0d random phases and the script",
               bytes_fed, pixel_bytes, phases_run);
      $display("checked %0d pixels, %0d frame ends, %0d register writes, %0d mismatches",
               pixels_checked, frames_closed, writes_done, mismatch_count);
      if (mismatch_count == 0 && pending_pixels.size() == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

endmodule

`default_nettype wire

// ===== bmp_pixel_grayscale_stream_unit.f =====
rtl/core/bmpgs_pkg.sv
rtl/core/bmpgs_byte_tracker.sv
rtl/core/bmp_pixel_grayscale_stream_unit.sv
test/bmp_pixel_grayscale_stream_unit_tb.sv
